/* design/assert_macros.svh */
// Assertion macros used by the lottery scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define LSCH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lottery scheduler check failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define LSCH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lottery scheduler check failed");

`endif

/* design/lsch_pkg.sv */
// Shared constants, codes and types of the lottery scheduler.
`timescale 1ns / 1ps

package lsch_pkg;

  localparam int CMD_W      = 2;
  localparam int SLOT_W     = 4;
  localparam int BURST_W    = 16;
  localparam int TICKET_W   = 5;
  localparam int DRAWN_W    = 9;
  localparam int TIME_W     = 20;
  localparam int STATUS_W   = 2;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int PCOUNT_W   = 5;

  // Largest ticket count one slot can hold, used to size the running ticket sum.
  localparam int TICKET_LIMIT = 31;
  localparam int DEFAULT_MAX_SLOTS = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_RAN       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FINISHED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_TICKET = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM       = 1'b1;

  // Data that travels down the cell chain during one sweep.
  typedef struct packed {
    logic              found;
    logic              started;
    logic              nz;
    logic [BURST_W-1:0] rem;
    logic [TIME_W-1:0] waited;
    logic [TIME_W-1:0] finish_at;
    logic [TIME_W-1:0] first_run_at;
  } lsch_stats_t;

  // Slot load, broadcast to every cell in the accept cycle.
  typedef struct packed {
    logic                we;
    logic [SLOT_W-1:0]   slot;
    logic [BURST_W-1:0]  burst;
    logic [TICKET_W-1:0] tickets;
  } lsch_load_t;

  // Result of a granted draw, broadcast to every cell.
  typedef struct packed {
    logic               apply;
    logic [BURST_W-1:0] ran;
    logic [TIME_W-1:0]  clock_old;
    logic [TIME_W-1:0]  clock_new;
  } lsch_commit_t;

endpackage

/* design/lsch_cell.sv */
// One slot cell: holds a slot's state and takes part in the ticket sweep.
`timescale 1ns / 1ps

module lsch_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5,
  parameter int CUM_W = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [CNT_W-1:0]              n_eff,
  input  logic [lsch_pkg::CMD_W-1:0]    cmd,
  input  logic [lsch_pkg::SLOT_W-1:0]   slot,
  input  logic [lsch_pkg::DRAWN_W-1:0]  drawn,
  input  lsch_pkg::lsch_load_t          load,
  input  lsch_pkg::lsch_commit_t        upd,
  input  logic [IDX_W-1:0]              win,
  input  logic                          carry_valid,
  input  logic [CUM_W-1:0]              carry_cum,
  input  logic [IDX_W-1:0]              carry_win,
  input  lsch_pkg::lsch_stats_t         carry_stats,
  output logic                          pass_valid,
  output logic [CUM_W-1:0]              pass_cum,
  output logic [IDX_W-1:0]              pass_win,
  output lsch_pkg::lsch_stats_t         pass_stats
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
  localparam logic [IDX_W-1:0] IDX_I = IDX_W'(IDX);

  logic [lsch_pkg::BURST_W-1:0]  rem;
  logic [lsch_pkg::TICKET_W-1:0] tix;
  logic [lsch_pkg::TIME_W-1:0]   waited;
  logic [lsch_pkg::TIME_W-1:0]   finish_at;
  logic [lsch_pkg::TIME_W-1:0]   first_run_at;
  logic                          started;

  logic                          active;
  logic                          read_hit;
  logic                          load_hit;
  logic                          win_hit;
  logic                          match;
  logic [CUM_W-1:0]              hi;
  logic [CUM_W-1:0]              drawn_x;
  logic [lsch_pkg::TIME_W:0]     wait_sum;
  logic [lsch_pkg::TIME_W-1:0]   wait_sat;
  lsch_pkg::lsch_stats_t         stats;

  always_comb begin
    active   = IDX_C < n_eff;
    read_hit = 32'(slot) == IDX;
    load_hit = 32'(load.slot) == IDX;
    win_hit  = win == IDX_I;
    hi       = carry_cum + CUM_W'(tix);
    drawn_x  = CUM_W'(drawn);
    // This slot owns tickets carry_cum+1 .. carry_cum+tix.
    match    = (cmd == lsch_pkg::CMD_DRAW) && active && !carry_stats.found &&
               (drawn_x > carry_cum) && (drawn_x <= hi);
    wait_sum = {1'b0, waited} + (lsch_pkg::TIME_W + 1)'(upd.ran);
    wait_sat = wait_sum[lsch_pkg::TIME_W] ? lsch_pkg::TIME_MAX
                                          : wait_sum[lsch_pkg::TIME_W-1:0];
    stats = carry_stats;
    if (match) begin
      stats.found   = 1'b1;
      stats.started = started;
      stats.rem     = rem;
    end
    if ((cmd == lsch_pkg::CMD_READ) && read_hit) begin
      stats.rem          = rem;
      stats.waited       = waited;
      stats.finish_at    = finish_at;
      stats.first_run_at = first_run_at;
    end
    // The winner is left out here; its new remaining burst is judged after the grant.
    if (active && !match && (rem != '0)) begin
      stats.nz = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_valid <= 1'b0;
    end else begin
      pass_valid <= carry_valid;
    end
  end

  always_ff @(posedge clk) begin
    pass_cum   <= active ? hi : carry_cum;
    pass_win   <= match ? IDX_I : carry_win;
    pass_stats <= stats;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem          <= '0;
      tix          <= '0;
      waited       <= '0;
      finish_at    <= '0;
      first_run_at <= '0;
      started      <= 1'b0;
    end else if (load.we && load_hit) begin
      rem          <= load.burst;
      tix          <= load.tickets;
      waited       <= '0;
      finish_at    <= '0;
      first_run_at <= '0;
      started      <= 1'b0;
    end else if (upd.apply) begin
      if (win_hit) begin
        rem     <= rem - upd.ran;
        started <= 1'b1;
        if (!started) begin
          first_run_at <= upd.clock_old;
        end
        if (rem == upd.ran) begin
          finish_at <= upd.clock_new;
        end
      end else if (active && (rem != '0)) begin
        waited <= wait_sat;
      end
    end
  end

endmodule

/* design/lottery_scheduler_unit.sv */
// Lottery scheduler top level: command port, configuration and slot cell chain.
`timescale 1ns / 1ps

// Each command (load, draw, read or no-op) is accepted when start is high and busy
// is low, and its single result appears on the result ports, after the sweep, grant
// and commit states, with done high for exactly one cycle; the receiver cannot stall
// it, so the result must be taken in that cycle. busy stays high from acceptance
// until the result is shown, and the next command can be accepted at the earliest at
// the edge that ends the result cycle, so one transaction is served at a time. The
// sweep walks the ticket sum through the chain of slot cells, one cell per cycle, and
// the output of the last cell is captured, followed by the grant state, the commit state
// and the result cycle. Configuration writes take effect at the clock edge where cfg_we
// is high.
module lottery_scheduler_unit #(
  parameter int MAX_SLOTS = lsch_pkg::DEFAULT_MAX_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [lsch_pkg::CMD_W-1:0]     cmd,
  input  logic [lsch_pkg::SLOT_W-1:0]    slot,
  input  logic [lsch_pkg::BURST_W-1:0]   burst,
  input  logic [lsch_pkg::TICKET_W-1:0]  tickets,
  input  logic [lsch_pkg::DRAWN_W-1:0]   ticket_drawn,
  input  logic                           cfg_we,
  input  logic [lsch_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsch_pkg::CFG_W-1:0]     cfg_data,
  output logic                           done,
  output logic [lsch_pkg::SLOT_W-1:0]    winner_slot,
  output logic [lsch_pkg::BURST_W-1:0]   ran,
  output logic [lsch_pkg::BURST_W-1:0]   remaining,
  output logic [lsch_pkg::TIME_W-1:0]    now_time,
  output logic [lsch_pkg::STATUS_W-1:0]  status,
  output logic                           all_done,
  output logic [lsch_pkg::TIME_W-1:0]    wait_time,
  output logic [lsch_pkg::TIME_W-1:0]    turnaround_time,
  output logic [lsch_pkg::TIME_W-1:0]    response_time
);

`include "assert_macros.svh"

  localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int CUM_RAW = $clog2(MAX_SLOTS * lsch_pkg::TICKET_LIMIT + 1);
  localparam int CUM_W   = (CUM_RAW > lsch_pkg::DRAWN_W) ? CUM_RAW : lsch_pkg::DRAWN_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SWEEP  = 4'b0010,
    S_GRANT  = 4'b0100,
    S_COMMIT = 4'b1000
  } lsch_state_t;

  lsch_state_t state;
  lsch_state_t state_next;

  logic [lsch_pkg::PCOUNT_W-1:0] process_count;
  logic [lsch_pkg::BURST_W-1:0]  quantum;
  logic [CNT_W-1:0]              n_eff;
  logic [lsch_pkg::BURST_W-1:0]  q_eff;

  logic                           accept;
  logic                           kick;
  logic [lsch_pkg::CMD_W-1:0]     cmd_q;
  logic [lsch_pkg::SLOT_W-1:0]    slot_q;
  logic [lsch_pkg::BURST_W-1:0]   burst_q;
  logic [lsch_pkg::DRAWN_W-1:0]   drawn_q;

  logic [lsch_pkg::TIME_W-1:0]    clock_now;
  logic [lsch_pkg::TIME_W:0]      clock_sum;
  logic [lsch_pkg::TIME_W-1:0]    clock_new;

  lsch_pkg::lsch_stats_t          fin_stats;
  logic [IDX_W-1:0]               fin_win;
  logic                           granted;
  logic [lsch_pkg::BURST_W-1:0]   ran_q;
  logic [lsch_pkg::BURST_W-1:0]   rem_left;

  lsch_pkg::lsch_load_t           load;
  lsch_pkg::lsch_commit_t         upd;

  logic                           chain_valid [MAX_SLOTS+1];
  logic [CUM_W-1:0]               chain_cum   [MAX_SLOTS+1];
  logic [IDX_W-1:0]               chain_win   [MAX_SLOTS+1];
  lsch_pkg::lsch_stats_t          chain_stats [MAX_SLOTS+1];
  logic                           last_valid;

  assign accept = start && !busy;
  assign busy   = state != S_IDLE;

  // Slots in use, held to 1 .. MAX_SLOTS.
  always_comb begin
    if (process_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(process_count) > MAX_SLOTS) begin
      n_eff = CNT_W'(MAX_SLOTS);
    end else begin
      n_eff = CNT_W'(process_count);
    end
    q_eff = (quantum == '0) ? lsch_pkg::BURST_W'(1) : quantum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= lsch_pkg::PCOUNT_W'(1);
      quantum       <= lsch_pkg::BURST_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsch_pkg::REG_PROCESS_COUNT: process_count <= cfg_data[lsch_pkg::PCOUNT_W-1:0];
        lsch_pkg::REG_QUANTUM:       quantum       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      slot_q  <= slot;
      burst_q <= burst;
      drawn_q <= ticket_drawn;
    end
  end

  // Loads are written into the cell at the accept edge; the sweep then sees them.
  always_comb begin
    load.we      = accept && (cmd == lsch_pkg::CMD_LOAD);
    load.slot    = slot;
    load.burst   = burst;
    load.tickets = tickets;
  end

  always_comb begin
    clock_sum     = {1'b0, clock_now} + (lsch_pkg::TIME_W + 1)'(ran_q);
    clock_new     = clock_sum[lsch_pkg::TIME_W] ? lsch_pkg::TIME_MAX
                                                : clock_sum[lsch_pkg::TIME_W-1:0];
    upd.apply     = (state == S_COMMIT) && granted;
    upd.ran       = ran_q;
    upd.clock_old = clock_now;
    upd.clock_new = clock_new;
  end

  assign chain_valid[0] = kick;
  assign chain_cum[0]   = '0;
  assign chain_win[0]   = '0;
  assign chain_stats[0] = '0;
  assign last_valid     = chain_valid[MAX_SLOTS];

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    lsch_cell #(
      .IDX   (g),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .CUM_W (CUM_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .n_eff       (n_eff),
      .cmd         (cmd_q),
      .slot        (slot_q),
      .drawn       (drawn_q),
      .load        (load),
      .upd         (upd),
      .win         (fin_win),
      .carry_valid (chain_valid[g]),
      .carry_cum   (chain_cum[g]),
      .carry_win   (chain_win[g]),
      .carry_stats (chain_stats[g]),
      .pass_valid  (chain_valid[g+1]),
      .pass_cum    (chain_cum[g+1]),
      .pass_win    (chain_win[g+1]),
      .pass_stats  (chain_stats[g+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_SWEEP;
      S_SWEEP:  if (last_valid) state_next = S_GRANT;
      S_GRANT:  state_next = S_COMMIT;
      S_COMMIT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kick      <= 1'b0;
      done      <= 1'b0;
      clock_now <= '0;
      granted   <= 1'b0;
    end else begin
      state <= state_next;
      kick  <= accept;
      done  <= state == S_COMMIT;
      if (state == S_GRANT) begin
        granted <= (cmd_q == lsch_pkg::CMD_DRAW) && fin_stats.found &&
                   (fin_stats.rem != '0);
      end
      if (upd.apply) begin
        clock_now <= clock_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_SWEEP) && last_valid) begin
      fin_stats <= chain_stats[MAX_SLOTS];
      fin_win   <= chain_win[MAX_SLOTS];
    end
    if (state == S_GRANT) begin
      ran_q <= ((cmd_q == lsch_pkg::CMD_DRAW) && fin_stats.found)
               ? ((fin_stats.rem < q_eff) ? fin_stats.rem : q_eff) : '0;
    end
  end

  assign rem_left = fin_stats.rem - ran_q;

  always_ff @(posedge clk) begin
    if (state == S_COMMIT) begin
      now_time        <= upd.apply ? clock_new : clock_now;
      winner_slot     <= slot_q;
      ran             <= '0;
      remaining       <= '0;
      status          <= lsch_pkg::ST_DONE;
      all_done        <= !fin_stats.nz;
      wait_time       <= '0;
      turnaround_time <= '0;
      response_time   <= '0;
      unique case (cmd_q)
        lsch_pkg::CMD_LOAD: begin
          remaining <= burst_q;
        end
        lsch_pkg::CMD_DRAW: begin
          winner_slot <= fin_stats.found ? lsch_pkg::SLOT_W'(fin_win) : '0;
          ran         <= ran_q;
          if (!fin_stats.found) begin
            status <= lsch_pkg::ST_NO_TICKET;
          end else if (granted) begin
            status    <= lsch_pkg::ST_RAN;
            remaining <= rem_left;
            all_done  <= !fin_stats.nz && (rem_left == '0);
          end else begin
            status <= lsch_pkg::ST_FINISHED;
          end
        end
        lsch_pkg::CMD_READ: begin
          remaining       <= fin_stats.rem;
          wait_time       <= fin_stats.waited;
          turnaround_time <= fin_stats.finish_at;
          response_time   <= fin_stats.first_run_at;
        end
        lsch_pkg::CMD_NOP: ;
        default: ;
      endcase
    end
  end

  `LSCH_ASSERT_NEXT(a_accept_busy, accept, busy)
  `LSCH_ASSERT_NOW(a_done_idle, done, state == S_IDLE)
  `LSCH_ASSERT_NOW(a_sweep_end, last_valid, state == S_SWEEP)
  `LSCH_ASSERT_NOW(a_ran_nonzero, done && (status == lsch_pkg::ST_RAN), ran != '0)
  `LSCH_ASSERT_NEXT(a_clock_grows, state == S_COMMIT, clock_now >= $past(clock_now))

endmodule

/* tb/lottery_scheduler_unit_tb.sv */
// Self-checking testbench for the lottery scheduler: random and directed commands.
`timescale 1ns / 1ps

module lottery_scheduler_unit_tb;
  import lsch_pkg::*;

  localparam int MAX_SLOTS = DEFAULT_MAX_SLOTS;
  localparam int LATENCY = MAX_SLOTS + 3;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [SLOT_W-1:0]   slot;
    logic [BURST_W-1:0]  burst;
    logic [TICKET_W-1:0] tickets;
    logic [DRAWN_W-1:0]  ticket_drawn;
  } sched_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   winner_slot;
    logic [BURST_W-1:0]  ran;
    logic [BURST_W-1:0]  remaining;
    logic [TIME_W-1:0]   now_time;
    logic [STATUS_W-1:0] status;
    logic                all_done;
    logic [TIME_W-1:0]   wait_time;
    logic [TIME_W-1:0]   turnaround_time;
    logic [TIME_W-1:0]   response_time;
  } sched_result_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [CMD_W-1:0]     cmd;
  logic [SLOT_W-1:0]    slot;
  logic [BURST_W-1:0]   burst;
  logic [TICKET_W-1:0]  tickets;
  logic [DRAWN_W-1:0]   ticket_drawn;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 done;
  logic [SLOT_W-1:0]    winner_slot;
  logic [BURST_W-1:0]   ran;
  logic [BURST_W-1:0]   remaining;
  logic [TIME_W-1:0]    now_time;
  logic [STATUS_W-1:0]  status;
  logic                 all_done;
  logic [TIME_W-1:0]    wait_time;
  logic [TIME_W-1:0]    turnaround_time;
  logic [TIME_W-1:0]    response_time;

  lottery_scheduler_unit #(.MAX_SLOTS(MAX_SLOTS)) dut (.*);

  // Predicted scheduler state and register copies.
  logic [BURST_W-1:0]  m_remaining [0:MAX_SLOTS-1];
  logic [TICKET_W-1:0] m_tickets   [0:MAX_SLOTS-1];
  logic [TIME_W-1:0]   m_waited    [0:MAX_SLOTS-1];
  logic [TIME_W-1:0]   m_finish    [0:MAX_SLOTS-1];
  logic [TIME_W-1:0]   m_first_run [0:MAX_SLOTS-1];
  logic                m_started   [0:MAX_SLOTS-1];
  logic [TIME_W-1:0]   m_clock;
  logic [PCOUNT_W-1:0] m_pcount;
  logic [BURST_W-1:0]  m_quantum;

  // Ticket counts as the stimulus generator expects them, ahead of the block.
  logic [TICKET_W-1:0] gen_tickets [0:MAX_SLOTS-1];

  sched_cmd_t    pending_cmds[$];
  sched_result_t expected_results[$];
  sched_cmd_t    presented;

  int  accepts, seen_accepts, gap_left, mismatches, settings, issued;
  int  n_ran, n_finished, n_no_ticket, n_other;
  bit  lazy, idle_on, clock_saturated;
  int  phase, k;
  logic [CFG_W-1:0] pc_word;

  function automatic int slots_in_use(input logic [PCOUNT_W-1:0] pc);
    int n;
    n = pc;
    if (n < 1) n = 1;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    return n;
  endfunction

  function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W-1:0] a,
                                                 input logic [BURST_W-1:0] b);
    logic [TIME_W:0] s;
    s = a + b;
    return (s > TIME_MAX) ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  function automatic sched_result_t run_scheduler(input sched_cmd_t c);
    sched_result_t r;
    int n, cum, win, i;
    bit found, finished_all;
    logic [BURST_W-1:0] q, step;
    r = '0;
    r.winner_slot = c.slot;
    r.status = ST_DONE;
    n = slots_in_use(m_pcount);
    case (c.cmd)
      CMD_LOAD: begin
        if (c.slot < MAX_SLOTS) begin
          m_remaining[c.slot] = c.burst;
          m_tickets[c.slot] = c.tickets;
          m_waited[c.slot] = '0;
          m_finish[c.slot] = '0;
          m_first_run[c.slot] = '0;
          m_started[c.slot] = 1'b0;
        end
        r.remaining = c.burst;
      end
      CMD_DRAW: begin
        r.winner_slot = '0;
        found = 1'b0;
        cum = 0;
        win = 0;
        for (i = 0; i < n; i++) begin
          if (!found) begin
            if (c.ticket_drawn > cum && c.ticket_drawn <= cum + m_tickets[i]) begin
              found = 1'b1;
              win = i;
            end
            cum += m_tickets[i];
          end
        end
        if (!found) begin
          r.status = ST_NO_TICKET;
        end else if (m_remaining[win] == '0) begin
          r.winner_slot = win[SLOT_W-1:0];
          r.status = ST_FINISHED;
        end else begin
          r.winner_slot = win[SLOT_W-1:0];
          q = (m_quantum == '0) ? BURST_W'(1) : m_quantum;
          step = (m_remaining[win] < q) ? m_remaining[win] : q;
          if (!m_started[win]) begin
            m_started[win] = 1'b1;
            m_first_run[win] = m_clock;
          end
          m_remaining[win] = m_remaining[win] - step;
          m_clock = sat_time(m_clock, step);
          for (i = 0; i < n; i++)
            if (i != win && m_remaining[i] != '0) m_waited[i] = sat_time(m_waited[i], step);
          if (m_remaining[win] == '0) m_finish[win] = m_clock;
          r.ran = step;
          r.remaining = m_remaining[win];
          r.status = ST_RAN;
        end
      end
      CMD_READ: begin
        if (c.slot < MAX_SLOTS) begin
          r.remaining = m_remaining[c.slot];
          r.wait_time = m_waited[c.slot];
          r.turnaround_time = m_finish[c.slot];
          r.response_time = m_first_run[c.slot];
        end
      end
      default: ;
    endcase
    finished_all = 1'b1;
    for (i = 0; i < n; i++)
      if (m_remaining[i] != '0) finished_all = 1'b0;
    r.now_time = m_clock;
    r.all_done = finished_all;
    return r;
  endfunction

  function automatic string fmt_result(input sched_result_t r);
    return $sformatf("slot=%0d ran=%0d rem=%0d now=%0d st=%0d all=%0b wt=%0d ta=%0d rs=%0d",
                     r.winner_slot, r.ran, r.remaining, r.now_time, r.status, r.all_done,
                     r.wait_time, r.turnaround_time, r.response_time);
  endfunction

  function automatic sched_cmd_t make_cmd(input logic [CMD_W-1:0] c,
                                          input logic [SLOT_W-1:0] s,
                                          input logic [BURST_W-1:0] b,
                                          input logic [TICKET_W-1:0] t,
                                          input logic [DRAWN_W-1:0] d);
    sched_cmd_t x;
    x.cmd = c;
    x.slot = s;
    x.burst = b;
    x.tickets = t;
    x.ticket_drawn = d;
    return x;
  endfunction

  task automatic queue_cmd(input sched_cmd_t c);
    if (c.cmd == CMD_LOAD) gen_tickets[c.slot] = c.tickets;
    pending_cmds.push_back(c);
  endtask

  // Waits until the block is drained, then writes both registers.
  task automatic configure(input logic [CFG_W-1:0] pc_val, input logic [CFG_W-1:0] q_val);
    @(negedge clk);
    while (pending_cmds.size() != 0 || issued != accepts || expected_results.size() != 0 ||
           start || busy)
      @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_PROCESS_COUNT;
    cfg_data <= pc_val;
    m_pcount = pc_val[PCOUNT_W-1:0];
    @(negedge clk);
    cfg_index <= REG_QUANTUM;
    cfg_data <= q_val;
    m_quantum = q_val;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Opens with a load of every slot in use, then mixes draws, loads, reads and no-ops.
  // The heavy variant uses long bursts and keeps the last slot waiting without tickets.
  task automatic queue_phase(input int count, input bit heavy);
    int n, total, i, sel;
    sched_cmd_t c;
    n = slots_in_use(m_pcount);
    for (i = 0; i < count; i++) begin
      c = make_cmd(CMD_W'($urandom), SLOT_W'($urandom), BURST_W'($urandom),
                   TICKET_W'($urandom), DRAWN_W'($urandom));
      if (heavy) begin
        c.burst = BURST_W'($urandom_range(32768, 65535));
      end else begin
        sel = $urandom_range(0, 9);
        if (sel == 0) c.burst = '0;
        else if (sel != 1) c.burst = BURST_W'($urandom_range(1, 30));
      end
      sel = $urandom_range(0, 99);
      if (i < n) begin
        c.cmd = CMD_LOAD;
        c.slot = SLOT_W'(i);
        if (heavy) c.tickets = (i == n - 1) ? '0 : TICKET_W'($urandom_range(1, 31));
      end else if (sel < (heavy ? 30 : 12)) begin
        c.cmd = CMD_LOAD;
        if (heavy) c.slot = SLOT_W'($urandom_range(0, n - 2));
        else if ($urandom_range(0, 4) != 0) c.slot = SLOT_W'($urandom_range(0, n - 1));
      end else if (sel < 76) begin
        c.cmd = CMD_DRAW;
        total = 0;
        for (int j = 0; j < n; j++) total += gen_tickets[j];
        if (total > 0 && $urandom_range(0, 99) < 85)
          c.ticket_drawn = DRAWN_W'($urandom_range(1, total));
      end else if (sel < 91) begin
        c.cmd = CMD_READ;
      end else begin
        c.cmd = CMD_NOP;
      end
      queue_cmd(c);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Driver: presents one command at a time and holds it until the block takes it.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && seen_accepts == accepts)) begin
      seen_accepts = accepts;
      if (lazy && busy) begin
        start <= 1'b0;
      end else if (lazy) begin
        lazy = 1'b0;
        gap_left = $urandom_range(0, 4);
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else begin
        presented = pending_cmds.pop_front();
        issued++;
        cmd <= presented.cmd;
        slot <= presented.slot;
        burst <= presented.burst;
        tickets <= presented.tickets;
        ticket_drawn <= presented.ticket_drawn;
        start <= 1'b1;
        lazy = idle_on && ($urandom_range(0, 2) == 0);
      end
    end
  end

  // Monitor: checks each strobed result and predicts each accepted command.
  always @(posedge clk) begin
    sched_result_t got, want;
    if (!rst) begin
      if (done) begin
        got = {winner_slot, ran, remaining, now_time, status, all_done,
               wait_time, turnaround_time, response_time};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no transaction pending: %s", $realtime, fmt_result(got));
        end else begin
          want = expected_results.pop_front();
          case (want.status)
            ST_RAN:       n_ran++;
            ST_FINISHED:  n_finished++;
            ST_NO_TICKET: n_no_ticket++;
            default:      n_other++;
          endcase
          if (want.now_time == TIME_MAX) clock_saturated = 1'b1;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch, expected %s", $realtime, fmt_result(want));
              $display("%0t:           actual   %s", $realtime, fmt_result(got));
            end
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(run_scheduler(presented));
        accepts++;
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_NOP;
    slot = '0;
    burst = '0;
    tickets = '0;
    ticket_drawn = '0;
    cfg_we = 1'b0;
    cfg_index = REG_PROCESS_COUNT;
    cfg_data = '0;
    presented = '0;
    for (k = 0; k < MAX_SLOTS; k++) begin
      m_remaining[k] = '0;
      m_tickets[k] = '0;
      m_waited[k] = '0;
      m_finish[k] = '0;
      m_first_run[k] = '0;
      m_started[k] = 1'b0;
      gen_tickets[k] = '0;
    end
    m_clock = '0;
    m_pcount = 1;
    m_quantum = 1;
    idle_on = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: one slot, quantum of one.
    queue_cmd(make_cmd(CMD_DRAW, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_LOAD, 0, 2, 1, 0));
    queue_cmd(make_cmd(CMD_DRAW, 0, 0, 0, 1));
    queue_cmd(make_cmd(CMD_DRAW, 0, 0, 0, 1));
    queue_cmd(make_cmd(CMD_DRAW, 0, 0, 0, 1));
    queue_cmd(make_cmd(CMD_READ, 0, 0, 0, 0));
    queue_cmd(make_cmd(CMD_NOP, 15, 16'hFFFF, 31, 511));
    queue_cmd(make_cmd(CMD_LOAD, 9, 16'hFFFF, 31, 511));
    queue_cmd(make_cmd(CMD_READ, 9, 0, 0, 0));
    queue_cmd(make_cmd(CMD_DRAW, 0, 0, 0, 511));
    // A zero slot count and a zero quantum both act as one.
    configure(16'hFFE0, 16'h0000);
    queue_cmd(make_cmd(CMD_LOAD, 0, 3, 31, 0));
    queue_cmd(make_cmd(CMD_DRAW, 0, 0, 0, 31));
    queue_cmd(make_cmd(CMD_DRAW, 0, 0, 0, 32));
    queue_cmd(make_cmd(CMD_READ, 15, 0, 0, 0));
    // A slot count above the limit is clamped to every slot.
    configure(16'h001F, 16'hFFFF);
    queue_cmd(make_cmd(CMD_LOAD, 1, 5, 0, 0));
    queue_cmd(make_cmd(CMD_LOAD, 15, 16'hFFFF, 31, 0));
    queue_cmd(make_cmd(CMD_DRAW, 0, 0, 0, 32));
    queue_cmd(make_cmd(CMD_DRAW, 0, 0, 0, 63));
    queue_cmd(make_cmd(CMD_DRAW, 0, 0, 0, 94));
    queue_cmd(make_cmd(CMD_DRAW, 0, 0, 0, 1));
    queue_cmd(make_cmd(CMD_READ, 9, 0, 0, 0));
    queue_cmd(make_cmd(CMD_READ, 15, 0, 0, 0));
    queue_cmd(make_cmd(CMD_LOAD, 2, 0, 16, 0));
    queue_cmd(make_cmd(CMD_DRAW, 0, 0, 0, 40));

    for (phase = 0; phase < 7; phase++) begin
      pc_word = CFG_W'($urandom);
      case (phase)
        0: pc_word[PCOUNT_W-1:0] = 16;
        1: pc_word[PCOUNT_W-1:0] = 1;
        2: pc_word[PCOUNT_W-1:0] = 0;
        3: pc_word[PCOUNT_W-1:0] = PCOUNT_W'($urandom_range(17, 31));
        4: pc_word[PCOUNT_W-1:0] = PCOUNT_W'($urandom_range(2, 15));
        5: pc_word[PCOUNT_W-1:0] = 16;
        default: pc_word[PCOUNT_W-1:0] = PCOUNT_W'($urandom_range(0, 31));
      endcase
      case (phase)
        0: configure(pc_word, 1);
        1: configure(pc_word, 0);
        2: configure(pc_word, CFG_W'($urandom_range(2, 40)));
        3: configure(pc_word, CFG_W'($urandom_range(1, 8)));
        4: configure(pc_word, CFG_W'($urandom_range(2, 16)));
        5: configure(pc_word, CFG_W'($urandom_range(0, 4)));
        default: configure(pc_word, CFG_W'($urandom_range(1, 40)));
      endcase
      idle_on = (phase != 3);
      queue_phase(100, 1'b0);
    end

    // Last part: long runs at the largest quantum push the clock and the waiting
    // times into saturation, with no idling on the command side.
    pc_word = CFG_W'($urandom);
    pc_word[PCOUNT_W-1:0] = 16;
    configure(pc_word, 16'hFFFF);
    idle_on = 1'b0;
    lazy = 1'b0;
    gap_left = 0;
    queue_phase(130, 1'b1);

    while (pending_cmds.size() != 0 || issued != accepts || expected_results.size() != 0)
      @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    if (expected_results.size() != 0) begin
      mismatches += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("%0d transactions over %0d register settings: %0d grants, %0d finished-slot draws,",
             accepts, settings, n_ran, n_finished);
    $display("%0d unowned tickets, %0d loads/reads/no-ops, clock saturated: %0b, mismatches: %0d",
             n_no_ticket, n_other, clock_saturated, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/lsch_pkg.sv
design/lsch_cell.sv
design/lottery_scheduler_unit.sv
tb/lottery_scheduler_unit_tb.sv
